// File: design/plist_pkg.sv
// Shared types and codes for the positional list engine.
package plist_pkg;

  // Command codes.
  localparam logic [2:0] CMD_APPEND    = 3'd0;
  localparam logic [2:0] CMD_PREPEND   = 3'd1;
  localparam logic [2:0] CMD_INSERT_AT = 3'd2;
  localparam logic [2:0] CMD_READ_AT   = 3'd3;
  localparam logic [2:0] CMD_REM_FIRST = 3'd4;
  localparam logic [2:0] CMD_REM_LAST  = 3'd5;
  localparam logic [2:0] CMD_REM_AT    = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Width of one list entry.
  localparam int DATA_W = 32;

  // One command transfer.
  typedef struct packed {
    logic [2:0]               command;
    logic [6:0]               position;
    logic signed [DATA_W-1:0] value;
  } request_t;

  // One result transfer.
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [6:0]               element_count;
  } response_t;

  // Shift controls broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_op_t;

endpackage

// File: design/positional_list_engine.sv
// Positional list engine: a row of shifting cells holding an ordered list.
// Every command except a valid read at gives its result in the cycle after transfer.
// A valid read at passes through rd_pos, the registered first level of the OR tree and the
// result register, with busy high until then. Other commands: one per cycle while busy is low.
// The receiver cannot stall: each result is strobed on done for exactly one cycle.
// Reset (synchronous, rst high) empties the list and clears the read pipeline.
module positional_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  plist_pkg::request_t   request,
  output logic                  done,
  output plist_pkg::response_t  response
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [PW-1:0]               pos_ext;
  logic [PW-1:0]               count_ext;
  logic [PW-1:0]               ins_pos;
  logic [PW-1:0]               op_pos;
  logic [PW-1:0]               rd_pos;
  logic                        try_ins;
  logic                        do_ins;
  logic                        do_rem;
  logic                        rd_ok;
  logic                        rd_valid1;
  logic                        rd_valid2;
  logic                        accept;
  logic [1:0]                  st;
  logic [plist_pkg::DATA_W-1:0] rd_imm;
  logic [plist_pkg::DATA_W-1:0] gathered;
  plist_pkg::cell_op_t         op;

  logic [plist_pkg::DATA_W-1:0] entries [CAPACITY];
  logic [plist_pkg::DATA_W-1:0] taps [CAPACITY];

  assign accept    = start && !busy;
  assign busy      = rd_valid1 || rd_valid2;
  assign pos_ext   = PW'(request.position);
  assign count_ext = PW'(count);

  // Command decode and checks against the current count.
  always_comb begin
    try_ins = 1'b0;
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    rd_ok   = 1'b0;
    st      = plist_pkg::ST_OK;
    rd_imm  = '0;
    ins_pos = pos_ext;
    op_pos  = pos_ext;
    case (request.command)
      plist_pkg::CMD_APPEND: begin
        try_ins = 1'b1;
        ins_pos = count_ext;
      end
      plist_pkg::CMD_PREPEND: begin
        try_ins = 1'b1;
        ins_pos = '0;
      end
      plist_pkg::CMD_INSERT_AT: begin
        try_ins = 1'b1;
      end
      plist_pkg::CMD_READ_AT: begin
        if (pos_ext < count_ext) begin
          rd_ok = 1'b1;
        end else begin
          rd_imm = '1;
          st     = plist_pkg::ST_BAD_POS;
        end
      end
      plist_pkg::CMD_REM_FIRST: begin
        if (count == '0) begin
          st = plist_pkg::ST_EMPTY;
        end else begin
          do_rem = 1'b1;
          op_pos = '0;
        end
      end
      plist_pkg::CMD_REM_LAST: begin
        if (count == '0) begin
          st = plist_pkg::ST_EMPTY;
        end else begin
          do_rem = 1'b1;
          op_pos = count_ext - PW'(1);
        end
      end
      plist_pkg::CMD_REM_AT: begin
        if (pos_ext >= count_ext) begin
          st = plist_pkg::ST_BAD_POS;
        end else begin
          do_rem = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (try_ins) begin
      if (ins_pos > count_ext) begin
        st = plist_pkg::ST_BAD_POS;
      end else if (count >= CW'(CAPACITY)) begin
        st = plist_pkg::ST_FULL;
      end else begin
        do_ins = 1'b1;
        op_pos = ins_pos;
      end
    end
  end

  // Count after the command.
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem) begin
      count_next = count - CW'(1);
    end
  end

  assign op.ins = accept && do_ins;
  assign op.rem = accept && do_rem;

  // The row of cells; the ends see zero from outside the row.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [plist_pkg::DATA_W-1:0] left_in;
    logic [plist_pkg::DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = entries[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = entries[i + 1];
    end
    plist_cell #(
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .op_pos  (op_pos),
      .value   (request.value),
      .left    (left_in),
      .right   (right_in),
      .sel_pos (rd_pos),
      .entry   (entries[i]),
      .tap     (taps[i])
    );
  end

  plist_gather #(
    .CAPACITY (CAPACITY)
  ) u_gather (
    .clk      (clk),
    .taps     (taps),
    .gathered (gathered)
  );

  // Count and read pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_valid1 <= 1'b0;
      rd_valid2 <= 1'b0;
      done      <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      rd_valid1 <= accept && rd_ok;
      rd_valid2 <= rd_valid1;
      done      <= (accept && !rd_ok) || rd_valid2;
    end
  end

  // Read position and result register.
  always_ff @(posedge clk) begin
    if (accept && rd_ok) begin
      rd_pos <= pos_ext;
    end
    if (rd_valid2) begin
      response.read_value    <= gathered;
      response.status        <= plist_pkg::ST_OK;
      response.element_count <= 7'(count);
    end else if (accept) begin
      response.read_value    <= rd_imm;
      response.status        <= st;
      response.element_count <= 7'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_quick_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !rd_ok) |=> done)
    else $error("missing result after a single-cycle command");

  a_read_flow: assert property (@(posedge clk) disable iff (rst)
    rd_valid1 |=> (rd_valid2 && !done))
    else $error("read pipeline broke");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    rd_valid2 |=> (done && !busy))
    else $error("read result not delivered");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("count changed during a read");

endmodule

// File: design/plist_cell.sv
// One list cell: holds the entry at a fixed position and shifts with its neighbors.
module plist_cell #(
  parameter int PW  = 7,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  plist_pkg::cell_op_t           op,
  input  logic [PW-1:0]                 op_pos,
  input  logic [plist_pkg::DATA_W-1:0]  value,
  input  logic [plist_pkg::DATA_W-1:0]  left,
  input  logic [plist_pkg::DATA_W-1:0]  right,
  input  logic [PW-1:0]                 sel_pos,
  output logic [plist_pkg::DATA_W-1:0]  entry,
  output logic [plist_pkg::DATA_W-1:0]  tap
);

  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  // Insert moves later entries back one place; remove pulls them forward.
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (MY_POS == op_pos) begin
        entry <= value;
      end else if (MY_POS > op_pos) begin
        entry <= left;
      end
    end else if (op.rem) begin
      if (MY_POS >= op_pos) begin
        entry <= right;
      end
    end
  end

  // The cell at the read position drives its entry; all others drive zero.
  assign tap = (MY_POS == sel_pos) ? entry : '0;

endmodule

// File: design/plist_gather.sv
// Two-level OR tree that collects the one selected cell entry for a read.
module plist_gather #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic [plist_pkg::DATA_W-1:0]  taps [CAPACITY],
  output logic [plist_pkg::DATA_W-1:0]  gathered
);

  localparam int GROUP = 8;
  localparam int NG    = (CAPACITY + GROUP - 1) / GROUP;

  logic [plist_pkg::DATA_W-1:0] grp [NG];

  // First level: each group of eight cells is combined and registered.
  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      logic [plist_pkg::DATA_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          acc = acc | taps[g * GROUP + k];
        end
      end
      grp[g] <= acc;
    end
  end

  // Second level: the group results are combined for the result register.
  always_comb begin
    gathered = '0;
    for (int g = 0; g < NG; g++) begin
      gathered = gathered | grp[g];
    end
  end

endmodule
